>>> sv/chisq_pkg.sv
// ----------------------------------------------------------------------------
// chisq_pkg
// Shared constants and width helpers for the 2x2 chi-square scoring block.
// ----------------------------------------------------------------------------
package chisq_pkg;

  // Default widths of the cell counts and of the score fraction.
  localparam int DEFAULT_COUNT_BITS = 16;
  localparam int DEFAULT_FRAC_BITS  = 16;

  // Number of entries in the queue between the front and the divider.
  localparam int QUEUE_DEPTH = 4;

  // Width of the scaled numerator N * (ad - bc)^2 * 2^FRAC_BITS.
  function automatic int num_bits(input int count_bits, input int frac_bits);
    return 5 * count_bits + 2 + frac_bits;
  endfunction

  // Width of the margin product (a+b)(c+d)(a+c)(b+d).
  function automatic int den_bits(input int count_bits);
    return 4 * count_bits + 4;
  endfunction

  // Width of the score, which never exceeds N * 2^FRAC_BITS.
  function automatic int score_bits(input int count_bits, input int frac_bits);
    return count_bits + 2 + frac_bits;
  endfunction

endpackage

>>> sv/chisq_front.sv
// ----------------------------------------------------------------------------
// chisq_front
// Five-stage front end: margins, cross products, zero-margin detection,
// and the numerator and denominator products handed to the divider.
// ----------------------------------------------------------------------------
module chisq_front
  import chisq_pkg::*;
#(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS,
  parameter int FRAC_BITS  = DEFAULT_FRAC_BITS,
  localparam int NW = num_bits(COUNT_BITS, FRAC_BITS),
  localparam int DW = den_bits(COUNT_BITS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_BITS-1:0] cell_a,
  input  logic [COUNT_BITS-1:0] cell_b,
  input  logic [COUNT_BITS-1:0] cell_c,
  input  logic [COUNT_BITS-1:0] cell_d,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NW-1:0]         out_num,
  output logic [DW-1:0]         out_den,
  output logic                  out_zero
);

  localparam int MW = COUNT_BITS + 1;       // one margin
  localparam int NT = COUNT_BITS + 2;       // table total
  localparam int PW = 2 * COUNT_BITS;       // cross product
  localparam int RW = 2 * COUNT_BITS + 2;   // product of two margins
  localparam int SW = 4 * COUNT_BITS;       // squared difference
  localparam int HW = 2 * COUNT_BITS;       // half of the squared difference
  localparam int LP = HW + NT;              // half product with the total
  localparam int PP = 5 * COUNT_BITS + 2;   // unscaled numerator

  logic [4:0] v;
  logic       en;

  // Stage 1 registers.
  logic [MW-1:0] r1, r2, k1, k2;
  logic [PW-1:0] ad, bc;
  // Stage 2 registers.
  logic [PW-1:0] diff;
  logic [NT-1:0] n2;
  logic          zm2;
  logic [RW-1:0] rr, kk;
  // Stage 3 registers.
  logic [SW-1:0] dsq;
  logic [NT-1:0] n3;
  logic          zm3;
  logic [DW-1:0] den3;
  // Stage 4 registers.
  logic [LP-1:0] plo, phi;
  logic [DW-1:0] den4;
  logic          zm4;
  // Stage 5 registers.
  logic [NW-1:0] num5;
  logic [DW-1:0] den5;
  logic          zm5;

  // The whole front advances together unless its last stage is blocked.
  assign en       = !v[4] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  // Margins and cross products.
  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= MW'(cell_a) + MW'(cell_b);
      r2 <= MW'(cell_c) + MW'(cell_d);
      k1 <= MW'(cell_a) + MW'(cell_c);
      k2 <= MW'(cell_b) + MW'(cell_d);
      ad <= PW'(cell_a) * PW'(cell_d);
      bc <= PW'(cell_b) * PW'(cell_c);
    end
  end

  // Absolute difference, total, zero check and pairwise margin products.
  always_ff @(posedge clk) begin
    if (en) begin
      diff <= (ad >= bc) ? (ad - bc) : (bc - ad);
      n2   <= NT'(r1) + NT'(r2);
      zm2  <= (r1 == '0) || (r2 == '0) || (k1 == '0) || (k2 == '0);
      rr   <= RW'(r1) * RW'(r2);
      kk   <= RW'(k1) * RW'(k2);
    end
  end

  // Square of the difference and the full denominator.
  always_ff @(posedge clk) begin
    if (en) begin
      dsq  <= SW'(diff) * SW'(diff);
      n3   <= n2;
      zm3  <= zm2;
      den3 <= DW'(rr) * DW'(kk);
    end
  end

  // Each half of the squared difference times the table total.
  always_ff @(posedge clk) begin
    if (en) begin
      plo  <= LP'(dsq[HW-1:0]) * LP'(n3);
      phi  <= LP'(dsq[SW-1:HW]) * LP'(n3);
      den4 <= den3;
      zm4  <= zm3;
    end
  end

  // Halves combined into the numerator, scaled by the fraction bits.
  always_ff @(posedge clk) begin
    if (en) begin
      num5 <= NW'((PP'(phi) << HW) + PP'(plo)) << FRAC_BITS;
      den5 <= den4;
      zm5  <= zm4;
    end
  end

  assign out_valid = v[4];
  assign out_num   = num5;
  assign out_den   = den5;
  assign out_zero  = zm5;

endmodule

>>> sv/chisq_queue.sv
// ----------------------------------------------------------------------------
// chisq_queue
// Small register FIFO that decouples the front end from the divider.
// ----------------------------------------------------------------------------
module chisq_queue
  import chisq_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entry[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

>>> sv/chisq_divider.sv
// ----------------------------------------------------------------------------
// chisq_divider
// Pipelined restoring divider, one quotient bit per stage, with the
// result register that faces the output queue interface.
// ----------------------------------------------------------------------------
module chisq_divider
  import chisq_pkg::*;
#(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS,
  parameter int FRAC_BITS  = DEFAULT_FRAC_BITS,
  localparam int NW = num_bits(COUNT_BITS, FRAC_BITS),
  localparam int DW = den_bits(COUNT_BITS),
  localparam int Q  = score_bits(COUNT_BITS, FRAC_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic          in_zero,
  output logic          out_valid,
  input  logic          out_pop,
  output logic [Q-1:0]  out_score,
  output logic          out_zero
);

  logic [DW-1:0] rem [Q];
  logic [Q-1:0]  low [Q];
  logic [Q-1:0]  quo [Q];
  logic [DW-1:0] dv  [Q];
  logic          zm  [Q];
  logic          v   [Q];
  logic          en;

  // The pipe moves unless a finished result is blocked by a full output.
  assign en       = !v[Q-1] || !out_valid || out_pop;
  assign in_ready = en;

  for (genvar i = 0; i < Q; i++) begin : g_stage
    logic [DW-1:0] r_in, d_in;
    logic [Q-1:0]  l_in, q_in;
    logic          z_in, v_in;
    logic [DW:0]   sh;
    logic          ge;

    // The quotient fits in Q bits, so the numerator bits above Q start
    // out as a remainder already below the divisor.
    if (i == 0) begin : g_first
      assign r_in = DW'(in_num[NW-1:Q]);
      assign l_in = in_num[Q-1:0];
      assign q_in = '0;
      assign d_in = in_den;
      assign z_in = in_zero;
      assign v_in = in_valid;
    end else begin : g_rest
      assign r_in = rem[i-1];
      assign l_in = low[i-1];
      assign q_in = quo[i-1];
      assign d_in = dv[i-1];
      assign z_in = zm[i-1];
      assign v_in = v[i-1];
    end

    // One restoring step: shift in the next numerator bit, try a subtract.
    assign sh = {r_in, l_in[Q-1]};
    assign ge = (sh >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? DW'(sh - {1'b0, d_in}) : DW'(sh);
        low[i] <= l_in << 1;
        quo[i] <= {q_in[Q-2:0], ge};
        dv[i]  <= d_in;
        zm[i]  <= z_in;
      end
    end
  end

  // Result register; a zero margin forces the score to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && v[Q-1]) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v[Q-1]) begin
      out_score <= zm[Q-1] ? '0 : quo[Q-1];
      out_zero  <= zm[Q-1];
    end
  end

endmodule

>>> sv/chi_square_2x2_score.sv
// ----------------------------------------------------------------------------
// chi_square_2x2_score
// Pearson chi-square score of a 2x2 contingency table in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Write a table by raising push with cell_a..cell_d while full is low; each
//   such cycle is one input transaction. Results leave through a queue-style
//   port: while empty is low, score and zero_margin hold the oldest result,
//   and raising pop takes it. score is the chi-square value with FRAC_BITS
//   fraction bits, truncated; zero_margin marks a table with an empty row or
//   column, and its score is then zero.
// Path and throughput:
//   A table passes through the five front stages, a queue entry, one
//   divider stage per quotient bit and the result register. One table is
//   taken and one result is given every cycle while pop takes each result.
// Reset and stalls:
//   rst clears the pipelines, the queue and the result register. When pop
//   stays low the divider holds, the queue fills, then the front holds and
//   full rises; nothing is dropped and the flow resumes with no gap.
// ----------------------------------------------------------------------------
module chi_square_2x2_score
  import chisq_pkg::*;
#(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS,
  parameter int FRAC_BITS  = DEFAULT_FRAC_BITS,
  localparam int SW = score_bits(COUNT_BITS, FRAC_BITS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [COUNT_BITS-1:0] cell_a,
  input  logic [COUNT_BITS-1:0] cell_b,
  input  logic [COUNT_BITS-1:0] cell_c,
  input  logic [COUNT_BITS-1:0] cell_d,
  output logic                  empty,
  input  logic                  pop,
  output logic [SW-1:0]         score,
  output logic                  zero_margin
);

  localparam int NW = num_bits(COUNT_BITS, FRAC_BITS);
  localparam int DW = den_bits(COUNT_BITS);
  localparam int QW = NW + DW + 1;

  logic          front_ready;
  logic          front_valid;
  logic [NW-1:0] front_num;
  logic [DW-1:0] front_den;
  logic          front_zero;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_head;
  logic          div_ready;
  logic          out_valid;

  assign full = !front_ready;

  // Front end: margins and products.
  chisq_front #(
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (push),
    .in_ready (front_ready),
    .cell_a   (cell_a),
    .cell_b   (cell_b),
    .cell_c   (cell_c),
    .cell_d   (cell_d),
    .out_valid(front_valid),
    .out_ready(!q_full),
    .out_num  (front_num),
    .out_den  (front_den),
    .out_zero (front_zero)
  );

  // Queue between front and divider.
  assign q_push = front_valid && !q_full;
  assign q_pop  = !q_empty && div_ready;

  chisq_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data({front_zero, front_den, front_num}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_head),
    .empty    (q_empty)
  );

  // Back end: pipelined division and result register.
  chisq_divider #(
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .in_ready (div_ready),
    .in_num   (q_head[NW-1:0]),
    .in_den   (q_head[NW+DW-1:NW]),
    .in_zero  (q_head[QW-1]),
    .out_valid(out_valid),
    .out_pop  (pop),
    .out_score(score),
    .out_zero (zero_margin)
  );

  assign empty = !out_valid;

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("queue written while full");

  // The divider never takes from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("queue read while empty");

  // A table with an empty margin always scores zero.
  a_zero_score: assert property (@(posedge clk) disable iff (rst)
    (!empty && zero_margin) |-> (score == '0))
    else $error("nonzero score with a zero margin");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");

endmodule
